@@ rtl/vu_pkg.sv @@
// Shared types and constants for the LED ring VU meter.
// Used by the front, the frame queue, the LED back end and the top level.
package vu_pkg;

	localparam int MAX_LEDS = 32;
	localparam int CNT_W    = $clog2(MAX_LEDS + 1);
	localparam int IDX_W    = 5;
	localparam int LEVEL_W  = 16;
	localparam int GAIN_W   = 12;
	localparam int COLOR_W  = 8;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		CFG_LED_COUNT = 3'd0,
		CFG_GAIN      = 3'd1,
		CFG_REVERSE   = 3'd2,
		CFG_MIRROR    = 3'd3,
		CFG_START     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] lit;
		logic [IDX_W-1:0] start;
		logic             mirror;
		logic             reverse;
	} frame_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             on;
		logic             lo;
		logic             single;
	} led_ctl_t;

endpackage

@@ rtl/vu_meter_led_sweep_unit.sv @@
// Top level of the LED ring VU meter sweep unit.
// Depends on vu_pkg, vu_front, vu_queue and vu_back.
//
// One level item in, one colored LED out per clock cycle for each LED of the ring
// in use (1 to 32), LED 0 first, last high on the final one. Frames that wait in
// the frame queue follow each other with no gap, so the LED sequencer of the back
// end sets the sustained item rate. After start is taken, an item passes the
// front's multiplier registers, the frame queue, the sequencer and the back-end
// pipeline registers before its first LED appears. Up to four items may wait
// between front and back end; busy is high while that room is used up. LED
// results come out as a one-cycle strobe on led_valid and cannot be held off.
// Configuration registers sit at byte addresses 0x00 (led_count), 0x04
// (intensity_gain), 0x08 (reverse_mode), 0x0C (mirror_mode) and 0x10 (start_led);
// write them only while no frame is in flight.
module vu_meter_led_sweep_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vu_pkg::PADDR_W-1:0]   paddr,
	input  logic [vu_pkg::PDATA_W-1:0]   pwdata,
	output logic [vu_pkg::PDATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [vu_pkg::LEVEL_W-1:0]   level,
	output logic                         led_valid,
	output logic [vu_pkg::IDX_W-1:0]     led_index,
	output logic [vu_pkg::COLOR_W-1:0]   red,
	output logic [vu_pkg::COLOR_W-1:0]   green,
	output logic                         last
);

	logic                        q_push;
	vu_pkg::frame_t              q_data;
	logic                        q_pop;
	vu_pkg::frame_t              q_head;
	logic                        q_empty;
	logic [vu_pkg::QCNT_W-1:0]   q_count;

	vu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.level   (level),
		.busy    (busy),
		.q_count (q_count),
		.q_push  (q_push),
		.q_data  (q_data)
	);

	vu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.count     (q_count)
	);

	vu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.led_valid (led_valid),
		.led_index (led_index),
		.red       (red),
		.green     (green),
		.last      (last)
	);

endmodule

@@ rtl/vu_front.sv @@
// Front part: configuration registers, item accept and lit-count computation.
// Depends on vu_pkg; pushes one frame descriptor per item into the frame queue.
module vu_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vu_pkg::PADDR_W-1:0]    paddr,
	input  logic [vu_pkg::PDATA_W-1:0]    pwdata,
	output logic [vu_pkg::PDATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          start,
	input  logic [vu_pkg::LEVEL_W-1:0]    level,
	output logic                          busy,
	input  logic [vu_pkg::QCNT_W-1:0]     q_count,
	output logic                          q_push,
	output vu_pkg::frame_t                q_data
);

	localparam int P1_W  = vu_pkg::LEVEL_W + vu_pkg::GAIN_W;
	localparam int P2_W  = P1_W + vu_pkg::CNT_W;
	localparam int RND_W = P2_W + 1;
	localparam int LIT_W = RND_W - 24;
	localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << 23;

	logic [vu_pkg::CNT_W-1:0]   led_count_q;
	logic [vu_pkg::GAIN_W-1:0]  gain_q;
	logic                       reverse_q;
	logic                       mirror_q;
	logic [vu_pkg::IDX_W-1:0]   start_led_q;

	logic                       wr_en;
	vu_pkg::cfg_idx_t           cfg_idx;
	logic [vu_pkg::CNT_W-1:0]   n_eff;
	logic                       accept;

	logic                       v_s1;
	logic [P1_W-1:0]            p1_s1;
	logic                       v_s2;
	logic [P2_W-1:0]            p2_s2;

	logic [RND_W-1:0]           rnd;
	logic [LIT_W-1:0]           lit_wide;
	logic [vu_pkg::CNT_W-1:0]   lit;
	logic [vu_pkg::QCNT_W-1:0]  load;

	function automatic logic [vu_pkg::CNT_W-1:0] mod_count(
		input logic [vu_pkg::IDX_W-1:0] v,
		input logic [vu_pkg::CNT_W-1:0] n
	);
		logic [vu_pkg::CNT_W:0] rem;
		rem = '0;
		for (int b = vu_pkg::IDX_W - 1; b >= 0; b--) begin
			rem = {rem[vu_pkg::CNT_W-1:0], v[b]};
			if (rem >= {1'b0, n})
				rem = rem - {1'b0, n};
		end
		return rem[vu_pkg::CNT_W-1:0];
	endfunction

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg_idx = vu_pkg::cfg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= vu_pkg::CNT_W'(24);
			gain_q      <= vu_pkg::GAIN_W'(256);
			reverse_q   <= 1'b0;
			mirror_q    <= 1'b0;
			start_led_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx)
				vu_pkg::CFG_LED_COUNT: led_count_q <= pwdata[vu_pkg::CNT_W-1:0];
				vu_pkg::CFG_GAIN:      gain_q      <= pwdata[vu_pkg::GAIN_W-1:0];
				vu_pkg::CFG_REVERSE:   reverse_q   <= pwdata[0];
				vu_pkg::CFG_MIRROR:    mirror_q    <= pwdata[0];
				vu_pkg::CFG_START:     start_led_q <= pwdata[vu_pkg::IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			vu_pkg::CFG_LED_COUNT: prdata = vu_pkg::PDATA_W'(led_count_q);
			vu_pkg::CFG_GAIN:      prdata = vu_pkg::PDATA_W'(gain_q);
			vu_pkg::CFG_REVERSE:   prdata = vu_pkg::PDATA_W'(reverse_q);
			vu_pkg::CFG_MIRROR:    prdata = vu_pkg::PDATA_W'(mirror_q);
			vu_pkg::CFG_START:     prdata = vu_pkg::PDATA_W'(start_led_q);
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		priority if (led_count_q == '0)
			n_eff = vu_pkg::CNT_W'(1);
		else if (led_count_q > vu_pkg::CNT_W'(vu_pkg::MAX_LEDS))
			n_eff = vu_pkg::CNT_W'(vu_pkg::MAX_LEDS);
		else
			n_eff = led_count_q;
	end

	assign load   = q_count + vu_pkg::QCNT_W'(v_s1) + vu_pkg::QCNT_W'(v_s2);
	assign busy   = load >= vu_pkg::QCNT_W'(vu_pkg::QDEPTH);
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			p1_s1 <= {{vu_pkg::GAIN_W{1'b0}}, level} * {{vu_pkg::LEVEL_W{1'b0}}, gain_q};
		if (v_s1)
			p2_s2 <= {{vu_pkg::CNT_W{1'b0}}, p1_s1} * {{P1_W{1'b0}}, n_eff};
	end

	assign rnd      = {1'b0, p2_s2} + ROUND_HALF;
	assign lit_wide = rnd[RND_W-1:24];
	assign lit      = (lit_wide > LIT_W'(n_eff)) ? n_eff : lit_wide[vu_pkg::CNT_W-1:0];

	always_comb begin
		q_push          = v_s2;
		q_data.n        = n_eff;
		q_data.lit      = lit;
		q_data.start    = vu_pkg::IDX_W'(mod_count(start_led_q, n_eff));
		q_data.mirror   = mirror_q;
		q_data.reverse  = reverse_q;
	end

endmodule

@@ rtl/vu_queue.sv @@
// Short frame queue between the front and the LED back end.
// Depends on vu_pkg for the frame descriptor type and the depth.
module vu_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  vu_pkg::frame_t            push_data,
	input  logic                      pop,
	output vu_pkg::frame_t            head,
	output logic                      empty,
	output logic [vu_pkg::QCNT_W-1:0] count
);

	vu_pkg::frame_t               entry_q [vu_pkg::QDEPTH];
	logic [vu_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [vu_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [vu_pkg::QCNT_W-1:0]    count_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = count_q == '0;
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/vu_back.sv @@
// LED back end: walks the ring one LED per cycle and colors each LED.
// Depends on vu_pkg; pops frame descriptors from the frame queue.
module vu_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  vu_pkg::frame_t             q_head,
	output logic                       q_pop,
	output logic                       led_valid,
	output logic [vu_pkg::IDX_W-1:0]   led_index,
	output logic [vu_pkg::COLOR_W-1:0] red,
	output logic [vu_pkg::COLOR_W-1:0] green,
	output logic                       last
);

	localparam int X_W   = vu_pkg::IDX_W + 9;
	localparam int R_W   = 17;
	localparam int P_W   = X_W + R_W;
	localparam int QD_W  = vu_pkg::COLOR_W + vu_pkg::IDX_W;
	localparam logic [vu_pkg::COLOR_W-1:0] FULL = '1;

	logic                        active_q;
	vu_pkg::frame_t              frame_q;
	logic [vu_pkg::IDX_W-1:0]    idx_q;
	logic [vu_pkg::IDX_W-1:0]    pos_q;

	logic                        finishing;
	logic [vu_pkg::CNT_W-1:0]    n_m1;
	logic [vu_pkg::CNT_W-1:0]    pos6;
	logic [vu_pkg::CNT_W:0]      lit_p1;
	logic [vu_pkg::CNT_W-1:0]    h;
	logic [vu_pkg::CNT_W:0]      sum_a;
	logic [vu_pkg::CNT_W:0]      a7;
	logic [vu_pkg::CNT_W-1:0]    sel;
	logic                        on;
	logic                        lo;
	logic [vu_pkg::IDX_W-1:0]    d5;
	logic [vu_pkg::IDX_W-1:0]    m;
	logic [X_W-1:0]              x;
	logic [vu_pkg::CNT_W-1:0]    head_pos;

	logic                        v_s1;
	vu_pkg::led_ctl_t            ctl_s1;
	logic [X_W-1:0]              x_s1;
	logic [vu_pkg::IDX_W-1:0]    d_s1;

	logic [P_W-1:0]              prod;
	logic                        v_s2;
	vu_pkg::led_ctl_t            ctl_s2;
	logic [X_W-1:0]              x_s2;
	logic [vu_pkg::IDX_W-1:0]    d_s2;
	logic [vu_pkg::COLOR_W-1:0]  q1_s2;

	logic [QD_W-1:0]             qd;
	logic [X_W-1:0]              rem;
	logic [vu_pkg::COLOR_W-1:0]  quo;
	logic [vu_pkg::COLOR_W-1:0]  red_c;
	logic [vu_pkg::COLOR_W-1:0]  green_c;

	logic                        v_s3;
	logic [vu_pkg::IDX_W-1:0]    idx_s3;
	logic [vu_pkg::COLOR_W-1:0]  red_s3;
	logic [vu_pkg::COLOR_W-1:0]  green_s3;
	logic                        last_s3;

	function automatic logic [R_W-1:0] recip(input logic [vu_pkg::IDX_W-1:0] d);
		logic [R_W-1:0] r;
		unique case (d)
			5'd1:    r = 17'd65536;
			5'd2:    r = 17'd32768;
			5'd3:    r = 17'd21845;
			5'd4:    r = 17'd16384;
			5'd5:    r = 17'd13107;
			5'd6:    r = 17'd10922;
			5'd7:    r = 17'd9362;
			5'd8:    r = 17'd8192;
			5'd9:    r = 17'd7281;
			5'd10:   r = 17'd6553;
			5'd11:   r = 17'd5957;
			5'd12:   r = 17'd5461;
			5'd13:   r = 17'd5041;
			5'd14:   r = 17'd4681;
			5'd15:   r = 17'd4369;
			5'd16:   r = 17'd4096;
			5'd17:   r = 17'd3855;
			5'd18:   r = 17'd3640;
			5'd19:   r = 17'd3449;
			5'd20:   r = 17'd3276;
			5'd21:   r = 17'd3120;
			5'd22:   r = 17'd2978;
			5'd23:   r = 17'd2849;
			5'd24:   r = 17'd2730;
			5'd25:   r = 17'd2621;
			5'd26:   r = 17'd2520;
			5'd27:   r = 17'd2427;
			5'd28:   r = 17'd2340;
			5'd29:   r = 17'd2259;
			5'd30:   r = 17'd2184;
			5'd31:   r = 17'd2114;
			default: r = '0;
		endcase
		return r;
	endfunction

	// sequencer
	assign n_m1      = frame_q.n - 1'b1;
	assign finishing = active_q && ({1'b0, idx_q} == n_m1);
	assign q_pop     = ~q_empty && (~active_q || finishing);
	assign head_pos  = (q_head.start == '0) ? '0 : q_head.n - {1'b0, q_head.start};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= 1'b0;
		else if (q_pop)
			active_q <= 1'b1;
		else if (finishing)
			active_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q <= q_head;
			idx_q   <= '0;
			pos_q   <= head_pos[vu_pkg::IDX_W-1:0];
		end else if (active_q) begin
			idx_q <= idx_q + 1'b1;
			pos_q <= ({1'b0, pos_q} == n_m1) ? '0 : pos_q + 1'b1;
		end
	end

	// fill decision and gradient numerator
	always_comb begin
		pos6   = {1'b0, pos_q};
		lit_p1 = {1'b0, frame_q.lit} + 1'b1;
		h      = lit_p1[vu_pkg::CNT_W:1];
		sum_a  = {1'b0, pos6} + {2'b0, frame_q.n[vu_pkg::CNT_W-1:1]};
		a7     = (sum_a >= {1'b0, frame_q.n}) ? sum_a - {1'b0, frame_q.n} : sum_a;
		sel    = frame_q.reverse ? a7[vu_pkg::CNT_W-1:0] : pos6;
		priority if (frame_q.mirror)
			on = (sel < h) || (({1'b0, sel} + {1'b0, h}) >= {1'b0, frame_q.n});
		else if (frame_q.reverse)
			on = ({1'b0, pos6} + {1'b0, frame_q.lit}) >= {1'b0, frame_q.n};
		else
			on = pos6 < frame_q.lit;
		d5 = n_m1[vu_pkg::IDX_W-1:0];
		lo = {pos6, 1'b0} < {1'b0, n_m1};
		m  = lo ? pos_q : d5 - pos_q;
		x  = {m, 9'b0} - X_W'({m, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= active_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1.idx    <= idx_q;
		ctl_s1.last   <= finishing;
		ctl_s1.on     <= on;
		ctl_s1.lo     <= lo;
		ctl_s1.single <= frame_q.n == vu_pkg::CNT_W'(1);
		x_s1          <= x;
		d_s1          <= d5;
	end

	// quotient estimate by reciprocal
	assign prod = {{R_W{1'b0}}, x_s1} * {{X_W{1'b0}}, recip(d_s1)};

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		x_s2   <= x_s1;
		d_s2   <= d_s1;
		q1_s2  <= prod[16 +: vu_pkg::COLOR_W];
	end

	// correct the estimate and pick colors
	always_comb begin
		qd  = {{vu_pkg::IDX_W{1'b0}}, q1_s2} * {{vu_pkg::COLOR_W{1'b0}}, d_s2};
		rem = x_s2 - {{(X_W-QD_W){1'b0}}, qd};
		quo = (rem >= X_W'(d_s2)) ? q1_s2 + 1'b1 : q1_s2;
		priority if (!ctl_s2.on) begin
			red_c   = '0;
			green_c = '0;
		end else if (ctl_s2.single) begin
			red_c   = '0;
			green_c = FULL;
		end else if (ctl_s2.lo) begin
			red_c   = quo;
			green_c = FULL;
		end else begin
			red_c   = FULL;
			green_c = quo;
		end
	end

	always_ff @(posedge clk) begin
		idx_s3   <= ctl_s2.idx;
		red_s3   <= red_c;
		green_s3 <= green_c;
		last_s3  <= ctl_s2.last;
	end

	assign led_valid = v_s3;
	assign led_index = idx_s3;
	assign red       = red_s3;
	assign green     = green_s3;
	assign last      = last_s3;

endmodule

@@ rtl/vu_checker.sv @@
// Port-level checks for the LED ring VU meter sweep unit.
// Depends on vu_pkg; bound to vu_meter_led_sweep_unit below.
module vu_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         led_valid,
	input logic [vu_pkg::IDX_W-1:0]     led_index,
	input logic [vu_pkg::COLOR_W-1:0]   red,
	input logic [vu_pkg::COLOR_W-1:0]   green,
	input logic                         last
);

	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && !last |=> led_valid)
		else $error("frame broken by a gap");

	a_index_advance: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && !last |=> led_index == $past(led_index) + 1'b1)
		else $error("LED index did not advance");

	a_frame_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && (!$past(led_valid) || $past(last)) |-> led_index == '0)
		else $error("frame does not start at LED 0");

	a_color_shape: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid |-> red == 8'd255 || green == 8'd255 || (red == 8'd0 && green == 8'd0))
		else $error("color off the gradient");

endmodule

bind vu_meter_led_sweep_unit vu_checker u_vu_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for vu_meter_led_sweep_unit: levels in, one colored LED per strobe out.
// Holds a frame scoreboard class that predicts each LED from its own register copy.
// Depends on vu_pkg and the vu_meter_led_sweep_unit RTL.
import vu_pkg::*;

typedef struct packed {
	logic [IDX_W-1:0]   idx;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic               last;
} led_px_t;

class vu_frame_scoreboard;
	logic [5:0]        led_count;
	logic [GAIN_W-1:0] gain;
	logic              rev;
	logic              mir;
	logic [IDX_W-1:0]  anchor;
	led_px_t           frame_q[$];
	int                errors;

	function new();
		led_count = 6'd24;
		gain      = 12'd256;
		rev       = 1'b0;
		mir       = 1'b0;
		anchor    = '0;
		errors    = 0;
	endfunction

	function void write_reg(int idx, logic [PDATA_W-1:0] v);
		case (idx)
			CFG_LED_COUNT: led_count = v[5:0];
			CFG_GAIN:      gain      = v[GAIN_W-1:0];
			CFG_REVERSE:   rev       = v[0];
			CFG_MIRROR:    mir       = v[0];
			CFG_START:     anchor    = v[IDX_W-1:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return frame_q.size();
	endfunction

	function bit led_on(int unsigned pos, int unsigned n, int unsigned lit);
		int unsigned h;
		int unsigned a;
		h = (lit + 1) / 2;
		if (mir) begin
			a = rev ? (pos + n / 2) % n : pos;
			return (a < h) || (a + h >= n);
		end
		if (rev)
			return pos + lit >= n;
		return pos < lit;
	endfunction

	function void note_level(logic [LEVEL_W-1:0] lvl);
		int unsigned       n;
		int unsigned       lit;
		int unsigned       a0;
		int unsigned       pos;
		int unsigned       d;
		longint unsigned   prod;
		longint unsigned   lit64;
		led_px_t           px;
		n = led_count;
		if (n < 1)
			n = 1;
		if (n > MAX_LEDS)
			n = MAX_LEDS;
		prod  = 64'(lvl) * 64'(gain) * 64'(n);
		lit64 = (prod + (64'd1 << 23)) >> 24;
		lit   = (lit64 > 64'(n)) ? n : int'(lit64);
		a0    = anchor % n;
		for (int unsigned i = 0; i < n; i++) begin
			pos      = (i + n - a0) % n;
			px.idx   = IDX_W'(i);
			px.red   = '0;
			px.green = '0;
			px.last  = (i + 1 == n);
			if (led_on(pos, n, lit)) begin
				if (n > 1) begin
					d = n - 1;
					if (2 * pos < d) begin
						px.red   = COLOR_W'((510 * pos) / d);
						px.green = 8'd255;
					end else begin
						px.red   = 8'd255;
						px.green = COLOR_W'((510 * (d - pos)) / d);
					end
				end else begin
					px.green = 8'd255;
				end
			end
			frame_q.push_back(px);
		end
	endfunction

	function void check_led(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] red,
			logic [COLOR_W-1:0] green, logic last);
		led_px_t exp_px;
		if (frame_q.size() == 0) begin
			$error("unexpected LED item: led_index %0d red %0d green %0d last %0d",
				idx, red, green, last);
			errors++;
			return;
		end
		exp_px = frame_q.pop_front();
		if (idx !== exp_px.idx) begin
			$error("led_index: expected %0d, got %0d", exp_px.idx, idx);
			errors++;
		end
		if (red !== exp_px.red) begin
			$error("red: expected %0d, got %0d", exp_px.red, red);
			errors++;
		end
		if (green !== exp_px.green) begin
			$error("green: expected %0d, got %0d", exp_px.green, green);
			errors++;
		end
		if (last !== exp_px.last) begin
			$error("last: expected %0d, got %0d", exp_px.last, last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REG_SLOTS    = (2 ** PADDR_W) / 4;
	localparam int RAND_PHASES  = 13;
	localparam int PHASE_ITEMS  = 15;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               start   = 1'b0;
	logic               busy;
	logic [LEVEL_W-1:0] level   = '0;
	logic               led_valid;
	logic [IDX_W-1:0]   led_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic               last;
	int                 cycles  = 0;

	vu_frame_scoreboard sb = new();

	vu_meter_led_sweep_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.start     (start),
		.busy      (busy),
		.level     (level),
		.led_valid (led_valid),
		.led_index (led_index),
		.red       (red),
		.green     (green),
		.last      (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("vu_meter_led_sweep_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && led_valid)
			sb.check_led(led_index, red, green, last);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 80);
	endfunction

	task automatic cfg_write(int idx, logic [PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * 4);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.write_reg(idx, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_cfg(int cnt, int g, int rv, int mr, int st);
		cfg_write(CFG_LED_COUNT, cnt);
		cfg_write(CFG_GAIN, g);
		cfg_write(CFG_REVERSE, rv);
		cfg_write(CFG_MIRROR, mr);
		cfg_write(CFG_START, st);
	endtask

	task automatic send_level(logic [LEVEL_W-1:0] v, int gap);
		start <= 1'b1;
		level <= v;
		do
			@(posedge clk);
		while (busy);
		sb.note_level(v);
		if (gap > 0) begin
			start <= 1'b0;
			level <= LEVEL_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int                 cnt;
		int                 g;
		int                 r;
		bit                 burst;
		logic [LEVEL_W-1:0] lvl;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_level(16'h0000, pick_gap());
		send_level(16'hFFFF, pick_gap());
		send_level(16'h8000, pick_gap());
		send_level(16'h2AAA, pick_gap());
		drain();

		set_cfg(0, 4095, 0, 0, 0);
		send_level(16'h0000, pick_gap());
		send_level(16'hFFFF, pick_gap());
		drain();

		set_cfg(63, 4095, 1, 0, 31);
		send_level(16'h0800, pick_gap());
		send_level(16'hFFFF, pick_gap());
		drain();

		set_cfg(32, 256, 0, 1, 5);
		send_level(16'h4000, pick_gap());
		send_level(16'h8000, pick_gap());
		send_level(16'hFFFF, pick_gap());
		drain();

		set_cfg(7, 256, 1, 1, 20);
		send_level(16'h3000, pick_gap());
		send_level(16'h9000, pick_gap());
		send_level(16'hFFFF, pick_gap());
		drain();

		set_cfg(2, 0, 0, 0, 1);
		send_level(16'hFFFF, pick_gap());
		drain();
		cfg_write(CFG_GAIN, 256);
		send_level(16'h4000, pick_gap());
		drain();

		cfg_write($urandom_range(CFG_START + 1, REG_SLOTS - 1), 32'hFFFF_FFFF);
		send_level(16'hC000, pick_gap());
		drain();

		set_cfg(1, 256, 1, 1, 17);
		send_level(16'h8000, pick_gap());
		send_level(16'h7FFF, pick_gap());
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				cnt = 0;
			else if (r == 1)
				cnt = $urandom_range(33, 63);
			else if (r == 2)
				cnt = MAX_LEDS;
			else
				cnt = $urandom_range(1, 32);
			r = $urandom_range(0, 5);
			if (r == 0)
				g = 4095;
			else if (r == 1)
				g = $urandom_range(0, 4095);
			else
				g = $urandom_range(128, 640);
			set_cfg(cnt, g, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 31));
			burst = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				lvl = LEVEL_W'($urandom) >> $urandom_range(0, 8);
				send_level(lvl, burst ? 0 : pick_gap());
			end
			drain();
		end

		if (sb.errors == 0)
			$display("vu_meter_led_sweep_unit test passed");
		else
			$display("vu_meter_led_sweep_unit test failed");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/vu_pkg.sv
rtl/vu_front.sv
rtl/vu_queue.sv
rtl/vu_back.sv
rtl/vu_meter_led_sweep_unit.sv
rtl/vu_checker.sv
dv/tb_top.sv
